/* design/rotation_matrix_to_quaternion_defines.svh */
// Assertion macros for the rotation matrix to quaternion top level.
`ifndef ROTATION_MATRIX_TO_QUATERNION_DEFINES_SVH
`define ROTATION_MATRIX_TO_QUATERNION_DEFINES_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define RMQ_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define RMQ_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/rmq_pkg.sv */
// Types shared by the rotation matrix to quaternion pipeline.
package rmq_pkg;

    localparam int NormBits = 30;

    typedef struct packed {
        logic signed [15:0] right_x;
        logic signed [15:0] right_y;
        logic signed [15:0] right_z;
        logic signed [15:0] down_x;
        logic signed [15:0] down_y;
        logic signed [15:0] down_z;
        logic signed [15:0] fwd_x;
        logic signed [15:0] fwd_y;
        logic signed [15:0] fwd_z;
    } t_in;

    typedef struct packed {
        logic signed [15:0] quat_w;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic               degenerate;
    } t_out;

    // Normalized magnitudes with their signs, carried down the pipeline.
    typedef struct packed {
        logic [3:0][NormBits-1:0] mag;
        logic [3:0]               neg;
        logic                     degen;
    } t_nrm;

endpackage

/* design/rmq_front.sv */
// Branch selection, magnitude extraction and block normalization of the vector.
module rmq_front import rmq_pkg::*; #(
    parameter int FRAC_BITS = 14
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  logic i_valid,
    input  t_in  i_data,
    output logic o_valid,
    output t_nrm o_nrm
);
    localparam int VW = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 3;
    localparam int PW = $clog2(VW);
    localparam int SW = NormBits + VW;
    localparam logic signed [VW-1:0] ONE = {{(VW-1){1'b0}}, 1'b1} << FRAC_BITS;

    logic signed [VW-1:0] m00, m10, m20, m01, m11, m21, m02, m12, m22, c_t, c_r;
    logic signed [VW-1:0] c_v [4];

    always_comb begin
        m00 = VW'(i_data.right_x);
        m10 = VW'(i_data.right_y);
        m20 = VW'(i_data.right_z);
        m01 = VW'(i_data.down_x);
        m11 = VW'(i_data.down_y);
        m21 = VW'(i_data.down_z);
        m02 = VW'(i_data.fwd_x);
        m12 = VW'(i_data.fwd_y);
        m22 = VW'(i_data.fwd_z);
        c_t = m00 + m11 + m22;
        priority if (c_t > 0) begin
            c_r = ONE + c_t;
            c_v[0] = c_r; c_v[1] = m21 - m12; c_v[2] = m02 - m20; c_v[3] = m10 - m01;
        end else if (m00 > m11 && m00 > m22) begin
            c_r = ONE + m00 - m11 - m22;
            c_v[0] = m21 - m12; c_v[1] = c_r; c_v[2] = m01 + m10; c_v[3] = m02 + m20;
        end else if (m11 > m22) begin
            c_r = ONE + m11 - m00 - m22;
            c_v[0] = m02 - m20; c_v[1] = m01 + m10; c_v[2] = c_r; c_v[3] = m12 + m21;
        end else begin
            c_r = ONE + m22 - m00 - m11;
            c_v[0] = m10 - m01; c_v[1] = m02 + m20; c_v[2] = m12 + m21; c_v[3] = c_r;
        end
    end

    logic                 r_a_valid, r_a_pos;
    logic signed [VW-1:0] r_a_v [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_pos <= (c_r > 0);
            for (int i = 0; i < 4; i++) r_a_v[i] <= c_v[i];
        end
    end

    // The leading one of the OR of all magnitudes is the leading one of the largest.
    logic [VW-1:0] c_mag [4];
    logic [VW-1:0] c_or;
    logic [PW-1:0] c_p, c_amt;
    logic          c_left;

    always_comb begin
        c_or = '0;
        for (int i = 0; i < 4; i++) begin
            c_mag[i] = r_a_v[i][VW-1] ? VW'(-r_a_v[i]) : VW'(r_a_v[i]);
            c_or     = c_or | c_mag[i];
        end
        c_p = '0;
        for (int i = 0; i < VW; i++) begin
            if (c_or[i]) c_p = PW'(i);
        end
        c_left = (int'(c_p) < NormBits - 1);
        c_amt  = c_left ? PW'(NormBits - 1 - int'(c_p)) : PW'(int'(c_p) - (NormBits - 1));
    end

    logic          r_b_valid, r_b_left, r_b_degen;
    logic [PW-1:0] r_b_amt;
    logic [VW-1:0] r_b_mag [4];
    logic [3:0]    r_b_neg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (i_en) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_left  <= c_left;
            r_b_amt   <= c_amt;
            r_b_degen <= !r_a_pos;
            for (int i = 0; i < 4; i++) begin
                r_b_mag[i] <= c_mag[i];
                r_b_neg[i] <= r_a_v[i][VW-1];
            end
        end
    end

    logic [SW-1:0] c_wide [4];
    t_nrm          n_nrm;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            c_wide[i] = r_b_left ? (SW'(r_b_mag[i]) << r_b_amt) : (SW'(r_b_mag[i]) >> r_b_amt);
            n_nrm.mag[i] = c_wide[i][NormBits-1:0];
        end
        n_nrm.neg   = r_b_neg;
        n_nrm.degen = r_b_degen;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) o_nrm <= n_nrm;
    end
endmodule

/* design/rmq_norm.sv */
// Squared norm of the normalized vector: four squares, then their sum.
module rmq_norm import rmq_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  t_nrm        i_nrm,
    output logic        o_valid,
    output t_nrm        o_nrm,
    output logic [61:0] o_sum
);
    logic        r_valid;
    t_nrm        r_nrm;
    logic [59:0] r_sq [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            o_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
            o_valid <= r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_nrm <= i_nrm;
            for (int i = 0; i < 4; i++) begin
                r_sq[i] <= 60'(i_nrm.mag[i]) * 60'(i_nrm.mag[i]);
            end
            o_nrm <= r_nrm;
            o_sum <= 62'(r_sq[0]) + 62'(r_sq[1]) + 62'(r_sq[2]) + 62'(r_sq[3]);
        end
    end
endmodule

/* design/rmq_isqrt.sv */
// Pipelined integer square root, one result bit per stage.
module rmq_isqrt import rmq_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  t_nrm        i_nrm,
    input  logic [61:0] i_sum,
    output logic        o_valid,
    output t_nrm        o_nrm,
    output logic [31:0] o_len
);
    localparam int NS = 32;

    logic [63:0] r_n   [1:NS];
    logic [63:0] r_res [1:NS];
    logic        r_v   [1:NS];
    t_nrm        r_nrm [1:NS];

    logic [63:0] c_n   [0:NS-1];
    logic [63:0] c_res [0:NS-1];
    logic        c_v   [0:NS-1];
    t_nrm        c_nrm [0:NS-1];

    assign c_n[0]   = 64'(i_sum);
    assign c_res[0] = '0;
    assign c_v[0]   = i_valid;
    assign c_nrm[0] = i_nrm;

    for (genvar k = 0; k < NS; k++) begin : g_stage
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
        logic [63:0] c_try, n_n, n_res;

        if (k > 0) begin : g_link
            assign c_n[k]   = r_n[k];
            assign c_res[k] = r_res[k];
            assign c_v[k]   = r_v[k];
            assign c_nrm[k] = r_nrm[k];
        end

        always_comb begin
            c_try = c_res[k] + BIT;
            if (c_n[k] >= c_try) begin
                n_n   = c_n[k] - c_try;
                n_res = (c_res[k] >> 1) + BIT;
            end else begin
                n_n   = c_n[k];
                n_res = c_res[k] >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_v[k+1] <= c_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_n[k+1]   <= n_n;
                r_res[k+1] <= n_res;
                r_nrm[k+1] <= c_nrm[k];
            end
        end
    end

    assign o_valid = r_v[NS];
    assign o_nrm   = r_nrm[NS];
    assign o_len   = r_res[NS][31:0];
endmodule

/* design/rmq_div.sv */
// Rounded division of each magnitude by the norm, one quotient bit per stage, four lanes.
module rmq_div import rmq_pkg::*; #(
    parameter int FRAC_BITS = 14
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  t_nrm        i_nrm,
    input  logic [31:0] i_len,
    output logic        o_valid,
    output t_out        o_data
);
    localparam int QB = FRAC_BITS + 2;
    localparam int CW = FRAC_BITS + 35;

    logic [CW-1:0] r_rem [0:QB][4];
    logic [QB-1:0] r_q   [0:QB][4];
    logic [CW-1:0] r_d   [0:QB];
    logic [3:0]    r_neg [0:QB];
    logic          r_dg  [0:QB];
    logic          r_v   [0:QB];

    // Numerator 2*a*one + L over divisor 2*L rounds half away from zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int l = 0; l < 4; l++) begin
                r_rem[0][l] <= (CW'(i_nrm.mag[l]) << (FRAC_BITS + 1)) + CW'(i_len);
                r_q[0][l]   <= '0;
            end
            r_d[0]   <= CW'({i_len, 1'b0});
            r_neg[0] <= i_nrm.neg;
            r_dg[0]  <= i_nrm.degen;
        end
    end

    for (genvar k = 0; k < QB; k++) begin : g_stage
        localparam int J = QB - 1 - k;
        logic [CW-1:0] c_dj;

        assign c_dj = r_d[k] << J;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_v[k+1] <= r_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int l = 0; l < 4; l++) begin
                    if (r_rem[k][l] >= c_dj) begin
                        r_rem[k+1][l] <= r_rem[k][l] - c_dj;
                        r_q[k+1][l]   <= r_q[k][l] | (QB'(1) << J);
                    end else begin
                        r_rem[k+1][l] <= r_rem[k][l];
                        r_q[k+1][l]   <= r_q[k][l];
                    end
                end
                r_d[k+1]   <= r_d[k];
                r_neg[k+1] <= r_neg[k];
                r_dg[k+1]  <= r_dg[k];
            end
        end
    end

    logic [QB+15:0]     c_qx  [4];
    logic [15:0]        c_sat [4];
    logic signed [15:0] c_part [4];
    t_out               n_data;

    always_comb begin
        for (int l = 0; l < 4; l++) begin
            c_qx[l]   = {16'b0, r_q[QB][l]};
            c_sat[l]  = (c_qx[l] > (QB+16)'(32767)) ? 16'h7fff : c_qx[l][15:0];
            c_part[l] = r_dg[QB] ? 16'sd0 :
                        (r_neg[QB][l] ? 16'(-c_sat[l]) : 16'(c_sat[l]));
        end
        n_data.quat_w     = c_part[0];
        n_data.quat_x     = c_part[1];
        n_data.quat_y     = c_part[2];
        n_data.quat_z     = c_part[3];
        n_data.degenerate = r_dg[QB];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r_v[QB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) o_data <= n_data;
    end
endmodule

/* design/rotation_matrix_to_quaternion.sv */
// Top level of the rotation matrix to quaternion pipeline with its output buffer.
//
// Converts a 3x3 rotation matrix (signed Q1.FRAC_BITS, columns right, down and
// forward) into a normalized quaternion by Shepperd's method, one matrix per clock
// cycle while the input is not stalled. The pipeline has 3 front stages (branch
// choice, magnitudes, block shift), 2 norm stages (squares, sum), 32 square-root
// stages, and FRAC_BITS + 4 division stages; the square root and the per-bit
// divider make up most of that depth. A two-entry output buffer takes results
// while the consumer stalls, and the input stalls only when that buffer is full.
// A matrix whose radicand is not positive gives zero parts with degenerate set.
`include "rotation_matrix_to_quaternion_defines.svh"
module rotation_matrix_to_quaternion import rmq_pkg::*; #(
    parameter int FRAC_BITS = 14
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data
);
    logic        en;
    logic        f_valid, n_valid, s_valid, d_valid;
    t_nrm        f_nrm, n_nrm, s_nrm;
    logic [61:0] n_sum;
    logic [31:0] s_len;
    t_out        d_data;

    rmq_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(i_in_valid), .i_data(i_in_data),
        .o_valid(f_valid), .o_nrm(f_nrm)
    );

    rmq_norm u_norm (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(f_valid), .i_nrm(f_nrm),
        .o_valid(n_valid), .o_nrm(n_nrm), .o_sum(n_sum)
    );

    rmq_isqrt u_isqrt (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(n_valid), .i_nrm(n_nrm), .i_sum(n_sum),
        .o_valid(s_valid), .o_nrm(s_nrm), .o_len(s_len)
    );

    rmq_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(s_valid), .i_nrm(s_nrm), .i_len(s_len),
        .o_valid(d_valid), .o_data(d_data)
    );

    logic [1:0] r_cnt;
    logic       r_rd;
    t_out       r_buf [2];
    logic       push, pop, wr;

    assign en          = (r_cnt != 2'd2);
    assign o_in_stall  = !en;
    assign push        = en && d_valid;
    assign pop         = o_out_valid && !i_out_stall;
    assign wr          = r_rd ^ r_cnt[0];
    assign o_out_valid = (r_cnt != 2'd0);
    assign o_out_data  = r_buf[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_rd  <= 1'b0;
        end else begin
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
            if (pop) r_rd <= !r_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_buf[wr] <= d_data;
    end

    `RMQ_ASSERT_IMP(a_degen_zero, o_out_valid && o_out_data.degenerate, o_out_data.quat_w == 16'sd0 && o_out_data.quat_x == 16'sd0 && o_out_data.quat_y == 16'sd0 && o_out_data.quat_z == 16'sd0, "degenerate result with nonzero parts")
    `RMQ_ASSERT_NXT(a_fill_stall, push && !pop && r_cnt == 2'd1, o_in_stall, "buffer filled without stalling the input")
    `RMQ_ASSERT_NXT(a_drain, pop && !push, r_cnt == $past(r_cnt) - 2'd1, "buffer count did not drop on a transfer out")
    `RMQ_ASSERT_IMP(a_cnt_range, 1'b1, r_cnt != 2'd3, "buffer count beyond its depth")
endmodule

/* sim/tb_rotation_matrix_to_quaternion.sv */
// Self-checking testbench for the rotation matrix to quaternion pipeline.
`timescale 1ns / 100ps
module tb_rotation_matrix_to_quaternion;
    import rmq_pkg::*;

    localparam int FRAC = 14;
    localparam int LATENCY = FRAC + 42;
    localparam int N_RANDOM = 1330;
    localparam longint CYCLE_LIMIT = 400000;
    localparam logic signed [15:0] ONE = 16'sd16384;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    t_in  i_in_data = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    t_out o_out_data;

    rotation_matrix_to_quaternion #(.FRAC_BITS(FRAC)) u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data)
    );

    always #1 i_clk = ~i_clk;

    t_out   quat_queue[$];
    int     err_count = 0;
    int     sent_count = 0;
    int     recv_count = 0;
    int     degen_count = 0;
    longint cycle_count = 0;
    int     send_idle_pct = 0;
    int     recv_idle_pct = 0;

    // Shepperd branch choice, then exact integer normalization.
    function automatic t_out quat_from_matrix(t_in m);
        longint m00, m10, m20, m01, m11, m21, m02, m12, m22, t, r, vv;
        longint v[4];
        longint unsigned mag[4];
        longint unsigned mx, nsum, len, q, bitv, rem;
        t_out res;
        m00 = m.right_x; m10 = m.right_y; m20 = m.right_z;
        m01 = m.down_x;  m11 = m.down_y;  m21 = m.down_z;
        m02 = m.fwd_x;   m12 = m.fwd_y;   m22 = m.fwd_z;
        t = m00 + m11 + m22;
        if (t > 0) begin
            r = (1 << FRAC) + t;
            v[0] = r; v[1] = m21 - m12; v[2] = m02 - m20; v[3] = m10 - m01;
        end else if (m00 > m11 && m00 > m22) begin
            r = (1 << FRAC) + m00 - m11 - m22;
            v[0] = m21 - m12; v[1] = r; v[2] = m01 + m10; v[3] = m02 + m20;
        end else if (m11 > m22) begin
            r = (1 << FRAC) + m11 - m00 - m22;
            v[0] = m02 - m20; v[1] = m01 + m10; v[2] = r; v[3] = m12 + m21;
        end else begin
            r = (1 << FRAC) + m22 - m00 - m11;
            v[0] = m10 - m01; v[1] = m02 + m20; v[2] = m12 + m21; v[3] = r;
        end
        res = '0;
        if (r <= 0) begin
            res.degenerate = 1'b1;
            return res;
        end
        mx = 0;
        for (int i = 0; i < 4; i++) begin
            vv = v[i];
            mag[i] = (vv < 0) ? -vv : vv;
            if (mag[i] > mx) mx = mag[i];
        end
        while (mx >= (64'd1 << 30)) begin
            for (int i = 0; i < 4; i++) mag[i] >>= 1;
            mx >>= 1;
        end
        while (mx < (64'd1 << 29)) begin
            for (int i = 0; i < 4; i++) mag[i] <<= 1;
            mx <<= 1;
        end
        nsum = 0;
        for (int i = 0; i < 4; i++) nsum += mag[i] * mag[i];
        // Bitwise integer square root.
        len = 0;
        rem = nsum;
        bitv = 64'd1 << 62;
        while (bitv > rem) bitv >>= 2;
        while (bitv != 0) begin
            if (rem >= len + bitv) begin
                rem -= len + bitv;
                len = (len >> 1) + bitv;
            end else begin
                len >>= 1;
            end
            bitv >>= 2;
        end
        for (int i = 0; i < 4; i++) begin
            q = (2 * mag[i] * (64'd1 << FRAC) + len) / (2 * len);
            if (q > 32767) q = 32767;
            if (v[i] < 0) q = -q;
            case (i)
                0: res.quat_w = q[15:0];
                1: res.quat_x = q[15:0];
                2: res.quat_y = q[15:0];
                default: res.quat_z = q[15:0];
            endcase
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch on result %0d: %s got %0d want %0d", recv_count, what, got, want);
        err_count++;
    endtask

    // Output side: random stall, compare each transfer with the oldest prediction.
    always @(posedge i_clk) begin
        t_out want;
        cycle_count <= cycle_count + 1;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (quat_queue.size() == 0) begin
                report_mismatch("unexpected transfer", 1, 0);
            end else begin
                want = quat_queue.pop_front();
                if (o_out_data.quat_w !== want.quat_w)
                    report_mismatch("quat_w", o_out_data.quat_w, want.quat_w);
                if (o_out_data.quat_x !== want.quat_x)
                    report_mismatch("quat_x", o_out_data.quat_x, want.quat_x);
                if (o_out_data.quat_y !== want.quat_y)
                    report_mismatch("quat_y", o_out_data.quat_y, want.quat_y);
                if (o_out_data.quat_z !== want.quat_z)
                    report_mismatch("quat_z", o_out_data.quat_z, want.quat_z);
                if (o_out_data.degenerate !== want.degenerate)
                    report_mismatch("degenerate", o_out_data.degenerate, want.degenerate);
                if (want.degenerate) degen_count++;
            end
            recv_count++;
        end
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Drives one matrix; the prediction is queued on the accepting edge.
    task automatic send_matrix(t_in m, t_out want, bit use_want);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= m;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        quat_queue.push_back(use_want ? want : quat_from_matrix(m));
        sent_count++;
        @(negedge i_clk);
    endtask

    function automatic logic [15:0] rand_elem();
        int sel;
        sel = $urandom_range(9);
        if (sel == 0) return 16'($urandom());
        if (sel == 1) return (($urandom_range(1) != 0) ? ONE : -ONE);
        return 16'($signed($urandom_range(32768)) - 16384);
    endfunction

    // Rotation about one axis by a random angle, sometimes with a small perturbation of right_y.
    function automatic t_in rand_rotation();
        real a, c, s;
        int ax;
        t_in m;
        a = ($urandom_range(65535) / 65535.0) * 6.2831853;
        c = $cos(a);
        s = $sin(a);
        ax = $urandom_range(2);
        m = '0;
        case (ax)
            0: begin
                m.right_x = ONE;
                m.down_y = 16'($rtoi(c * 16384)); m.down_z = 16'($rtoi(s * 16384));
                m.fwd_y = 16'(-$rtoi(s * 16384)); m.fwd_z = 16'($rtoi(c * 16384));
            end
            1: begin
                m.down_y = ONE;
                m.right_x = 16'($rtoi(c * 16384)); m.right_z = 16'(-$rtoi(s * 16384));
                m.fwd_x = 16'($rtoi(s * 16384)); m.fwd_z = 16'($rtoi(c * 16384));
            end
            default: begin
                m.fwd_z = ONE;
                m.right_x = 16'($rtoi(c * 16384)); m.right_y = 16'($rtoi(s * 16384));
                m.down_x = 16'(-$rtoi(s * 16384)); m.down_y = 16'($rtoi(c * 16384));
            end
        endcase
        if ($urandom_range(3) == 0) m.right_y = m.right_y + 16'($urandom_range(15)) - 16'sd7;
        return m;
    endfunction

    function automatic t_in mat(int a, int b, int c, int d, int e, int f, int g, int h, int k);
        t_in m;
        m.right_x = 16'(a); m.right_y = 16'(b); m.right_z = 16'(c);
        m.down_x = 16'(d);  m.down_y = 16'(e);  m.down_z = 16'(f);
        m.fwd_x = 16'(g);   m.fwd_y = 16'(h);   m.fwd_z = 16'(k);
        return m;
    endfunction

    function automatic t_out quat(int w, int x, int y, int z, bit dg);
        t_out q;
        q.quat_w = 16'(w); q.quat_x = 16'(x); q.quat_y = 16'(y); q.quat_z = 16'(z);
        q.degenerate = dg;
        return q;
    endfunction

    typedef struct {
        t_in  m;
        t_out q;
        bit   known;
    } t_row;

    t_row dir_rows[$];

    task automatic wait_drain();
        i_in_valid <= 1'b0;
        while (quat_queue.size() != 0) @(negedge i_clk);
    endtask

    initial begin
        t_in m;
        dir_rows.push_back('{mat(16384, 0, 0, 0, 16384, 0, 0, 0, 16384),
                             quat(16384, 0, 0, 0, 0), 1});
        dir_rows.push_back('{mat(16384, 0, 0, 0, -16384, 0, 0, 0, -16384),
                             quat(0, 16384, 0, 0, 0), 1});
        dir_rows.push_back('{mat(-16384, 0, 0, 0, 16384, 0, 0, 0, -16384),
                             quat(0, 0, 16384, 0, 0), 1});
        dir_rows.push_back('{mat(-16384, 0, 0, 0, -16384, 0, 0, 0, 16384),
                             quat(0, 0, 0, 16384, 0), 1});
        // Equal diagonal elements fall through to the last branch.
        dir_rows.push_back('{mat(-16384, 0, 0, 0, -16384, 0, 0, 0, -16384),
                             quat(0, 0, 0, 16384, 0), 1});
        dir_rows.push_back('{mat(0, 0, 0, 0, 0, 0, 0, 0, 0), quat(0, 0, 0, 16384, 0), 1});
        dir_rows.push_back('{mat(-32768, 0, 0, 0, -32768, 0, 0, 0, -32768),
                             quat(0, 0, 0, 16384, 0), 1});
        // Ties fall to the later branch.
        dir_rows.push_back('{mat(0, 100, 0, 0, 0, 0, 0, 0, -5), '0, 0});
        dir_rows.push_back('{mat(-3, 0, 0, 0, 0, 0, 0, 0, 0), '0, 0});
        dir_rows.push_back('{mat(-8000, 50, 60, 70, -8000, 80, 90, 11, -8000), '0, 0});
        dir_rows.push_back('{mat(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767,
                                 32767), '0, 0});
        dir_rows.push_back('{mat(32767, -32768, 32767, -32768, 32767, -32768, 32767,
                                 -32768, 32767), '0, 0});
        dir_rows.push_back('{mat(-32768, 32767, -32768, 32767, -32768, 32767, -32768,
                                 32767, -32768), '0, 0});
        dir_rows.push_back('{mat(0, 16384, 0, -16384, 0, 0, 0, 0, 16384), '0, 0});
        dir_rows.push_back('{mat(11585, 11585, 0, -11585, 11585, 0, 0, 0, 16384), '0, 0});
        dir_rows.push_back('{mat(1, -1, 1, -1, 1, -1, 1, -1, 1), '0, 0});

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_idle_pct = 18;
        recv_idle_pct = 46;
        foreach (dir_rows[i]) send_matrix(dir_rows[i].m, dir_rows[i].q, dir_rows[i].known);
        // Hold the input until the pipeline has emptied.
        wait_drain();

        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 18 : (ph == 1) ? 46 : 0;
            recv_idle_pct = (ph == 0) ? 46 : (ph == 1) ? 18 : 0;
            for (int n = 0; n < N_RANDOM / 3; n++) begin
                if ($urandom_range(9) < 7) begin
                    m = rand_rotation();
                end else begin
                    m = mat(rand_elem(), rand_elem(), rand_elem(), rand_elem(), rand_elem(),
                            rand_elem(), rand_elem(), rand_elem(), rand_elem());
                end
                send_matrix(m, '0, 0);
            end
        end

        wait_drain();
        repeat (LATENCY + 10) @(negedge i_clk);
        $display("sent %0d matrices, checked %0d quaternions (%0d degenerate)",
                 sent_count, recv_count, degen_count);
        if (err_count == 0 && quat_queue.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches, %0d results missing", err_count, quat_queue.size());
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
